@@ hw/rtl/bbbl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbbl_pkg
// Types and constants shared by the battery bar breathing LED block.
// ----------------------------------------------------------------------------
package bbbl_pkg;

   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_STOP    = 2'd1;
   localparam logic [1:0] FUNC_FRAME   = 2'd2;
   localparam logic [1:0] FUNC_BATTERY = 2'd3;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_ALERT  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_PER_CYCLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_START_LEVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_STOP_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_INTERVAL_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_LENGTH_MS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_HIGH        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MIDDLE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_LOW         = 3'd7;

   localparam logic [15:0] RST_FRAMES_PER_CYCLE  = 16'd60;
   localparam logic [6:0]  RST_ALERT_START_LEVEL = 7'd20;
   localparam logic [6:0]  RST_ALERT_STOP_LEVEL  = 7'd5;
   localparam logic [31:0] RST_ALERT_INTERVAL_MS = 32'd300000;
   localparam logic [31:0] RST_ALERT_LENGTH_MS   = 32'd3000;

   localparam logic [15:0] MIN_PERIOD  = 16'd2;
   localparam logic [15:0] SEG_STEP    = 16'd300;
   localparam logic [15:0] SEG_MIDDLE  = 16'd100;
   localparam logic [15:0] SEG_HIGH    = 16'd200;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] start_frames;
      logic [6:0]  charge_pct;
      logic [62:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [POS_W-1:0] bar_position;
      logic [15:0]      hue;
      logic [7:0]       saturation;
      logic [7:0]       lightness;
      logic [31:0]      frames_left;
      logic [31:0]      alert_duration;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] frames_per_cycle;
      logic [6:0]  alert_start_level;
      logic [6:0]  alert_stop_level;
      logic [31:0] alert_interval_ms;
      logic [31:0] alert_length_ms;
      logic [31:0] hsl_high;
      logic [31:0] hsl_middle;
      logic [31:0] hsl_low;
   } cfg_type;

endpackage
`default_nettype wire

@@ hw/rtl/bbbl_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbbl_csr
// Configuration registers with their reset values.
// ----------------------------------------------------------------------------
module bbbl_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bbbl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata,
   output bbbl_pkg::cfg_type                   cfg
);

   bbbl_pkg::cfg_type cfg_ff;
   bbbl_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbbl_pkg::CSR_FRAMES_PER_CYCLE:  cfg_in.frames_per_cycle  = csr_wdata[15:0];
            bbbl_pkg::CSR_ALERT_START_LEVEL: cfg_in.alert_start_level = csr_wdata[6:0];
            bbbl_pkg::CSR_ALERT_STOP_LEVEL:  cfg_in.alert_stop_level  = csr_wdata[6:0];
            bbbl_pkg::CSR_ALERT_INTERVAL_MS: cfg_in.alert_interval_ms = csr_wdata;
            bbbl_pkg::CSR_ALERT_LENGTH_MS:   cfg_in.alert_length_ms   = csr_wdata;
            bbbl_pkg::CSR_COLOR_HIGH:        cfg_in.hsl_high          = csr_wdata;
            bbbl_pkg::CSR_COLOR_MIDDLE:      cfg_in.hsl_middle        = csr_wdata;
            bbbl_pkg::CSR_COLOR_LOW:         cfg_in.hsl_low           = csr_wdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frames_per_cycle  <= bbbl_pkg::RST_FRAMES_PER_CYCLE;
         cfg_ff.alert_start_level <= bbbl_pkg::RST_ALERT_START_LEVEL;
         cfg_ff.alert_stop_level  <= bbbl_pkg::RST_ALERT_STOP_LEVEL;
         cfg_ff.alert_interval_ms <= bbbl_pkg::RST_ALERT_INTERVAL_MS;
         cfg_ff.alert_length_ms   <= bbbl_pkg::RST_ALERT_LENGTH_MS;
         cfg_ff.hsl_high          <= '0;
         cfg_ff.hsl_middle        <= '0;
         cfg_ff.hsl_low           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/bbbl_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbbl_div
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbbl_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [15:0]      remainder
);

   logic [15:0]                    rem_ff, rem_in;
   logic [31:0]                    quo_ff, quo_in;
   logic [15:0]                    dvs_ff, dvs_in;
   logic [bbbl_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [16:0]                    shifted;
   logic [16:0]                    diff;
   logic                           ge;

   assign shifted   = {rem_ff, quo_ff[31]};
   assign ge        = shifted >= {1'b0, dvs_ff};
   assign diff      = shifted - {1'b0, dvs_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = ge ? diff[15:0] : shifted[15:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + bbbl_pkg::DIV_CNT_W'(1);
         if (cnt_ff == bbbl_pkg::DIV_CNT_W'(bbbl_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/battery_bar_breathing_led.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// battery_bar_breathing_led
// Battery bar-graph animator: start/stop/frame/battery items in, HSL pixel,
// alert and status items out.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   req      req_valid/req_stall  bbbl_pkg::req_type
//   rsp      rsp_valid/rsp_stall  bbbl_pkg::rsp_type
//   csr      csr_valid/csr_ready  csr_index, csr_wdata
//
// Start, stop, battery and idle frame items: result held in pend_ff, then
// registered from ST_PUT when the output is free; next item accepted once
// back in ST_IDLE. Running frame item: on the bit-serial divider, one peak
// remainder, then point and lightness divisions per pixel.
// One item at a time; req_stall is high until the last result is registered.
// Output register holds a result under rsp_stall. Reset is synchronous.
// ----------------------------------------------------------------------------
module battery_bar_breathing_led #(
   parameter int BAR_PIXELS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire bbbl_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output bbbl_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bbbl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PUT   = 3'd1;
   localparam logic [2:0] ST_PEAK  = 3'd2;
   localparam logic [2:0] ST_POINT = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_LIGHT = 3'd5;

   localparam logic [15:0]                SCALE    = 16'(BAR_PIXELS * 3);
   localparam logic [15:0]                PIX_DIV  = 16'(BAR_PIXELS);
   localparam logic [bbbl_pkg::POS_W-1:0] LAST_POS = bbbl_pkg::POS_W'(BAR_PIXELS - 1);

   bbbl_pkg::cfg_type cfg;

   logic [2:0]                 state_ff, state_in;
   logic [31:0]                frames_ff, frames_in;
   logic [62:0]                last_alert_ff, last_alert_in;
   bbbl_pkg::rsp_type          pend_ff, pend_in;
   logic                       pix_run_ff, pix_run_in;
   logic [bbbl_pkg::POS_W-1:0] idx_ff, idx_in;
   logic [31:0]                num_ff, num_in;
   logic [15:0]                thr_ff, thr_in;
   logic [15:0]                scaled_ff, scaled_in;
   logic [15:0]                peak_ff, peak_in;
   logic [15:0]                gap_ff, gap_in;
   logic [31:0]                color_ff, color_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bbbl_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic        div_start;
   logic [31:0] div_dividend;
   logic [15:0] div_divisor;
   logic        div_done;
   logic [31:0] div_quo;
   logic [15:0] div_rem;

   logic        req_acc;
   logic        out_free;
   logic [15:0] period;
   logic [15:0] half;
   logic [15:0] two_h;
   logic [15:0] point;
   logic [15:0] gap_raw;
   logic [23:0] prod;
   logic [63:0] alert_due;
   logic        alert_ok;
   logic [31:0] num_next;

   bbbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bbbl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign period    = (cfg.frames_per_cycle < bbbl_pkg::MIN_PERIOD) ? bbbl_pkg::MIN_PERIOD
                                                                     : cfg.frames_per_cycle;
   assign half      = {1'b0, period[15:1]};
   assign two_h     = {period[15:1], 1'b0};
   assign point     = div_quo[15:0];
   assign gap_raw   = (point >= peak_ff) ? (point - peak_ff) : (peak_ff - point);
   assign prod      = 24'(color_ff[31:24]) * 24'(two_h - gap_ff);
   assign num_next  = num_ff + 32'(period);
   assign alert_due = {1'b0, last_alert_ff} + 64'(cfg.alert_interval_ms);
   assign alert_ok  = (frames_ff == '0)
                   && (cfg.alert_stop_level < req_data.charge_pct)
                   && (req_data.charge_pct < cfg.alert_start_level)
                   && ({1'b0, req_data.now_ms} > alert_due);

   always_comb begin
      state_in      = state_ff;
      frames_in     = frames_ff;
      last_alert_in = last_alert_ff;
      pend_in       = pend_ff;
      pix_run_in    = pix_run_ff;
      idx_in        = idx_ff;
      num_in        = num_ff;
      thr_in        = thr_ff;
      scaled_in     = scaled_ff;
      peak_in       = peak_ff;
      gap_in        = gap_ff;
      color_in      = color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = num_ff;
      div_divisor   = PIX_DIV;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pend_in      = '0;
               pend_in.kind = bbbl_pkg::KIND_STATUS;
               pend_in.last = 1'b1;
               pix_run_in   = 1'b0;
               state_in     = ST_PUT;
               unique case (req_data.func)
                  bbbl_pkg::FUNC_START: begin
                     last_alert_in = req_data.now_ms;
                     frames_in     = req_data.start_frames;
                  end
                  bbbl_pkg::FUNC_STOP: begin
                     last_alert_in = req_data.now_ms;
                     frames_in     = '0;
                  end
                  bbbl_pkg::FUNC_BATTERY: begin
                     if (alert_ok) begin
                        last_alert_in          = req_data.now_ms;
                        pend_in.kind           = bbbl_pkg::KIND_ALERT;
                        pend_in.alert_duration = cfg.alert_length_ms;
                     end
                  end
                  bbbl_pkg::FUNC_FRAME: begin
                     if (frames_ff != '0) begin
                        frames_in    = frames_ff - 32'd1;
                        div_start    = 1'b1;
                        div_dividend = frames_ff;
                        div_divisor  = period;
                        idx_in       = '0;
                        num_in       = '0;
                        thr_in       = '0;
                        scaled_in    = 16'(req_data.charge_pct) * SCALE;
                        pix_run_in   = 1'b1;
                        state_in     = ST_PEAK;
                     end
                  end
                  default: state_in = ST_PUT;
               endcase
            end
         end
         ST_PEAK: begin
            if (div_done) begin
               peak_in   = div_rem;
               div_start = 1'b1;
               state_in  = ST_POINT;
            end
         end
         ST_POINT: begin
            if (div_done) begin
               gap_in = (gap_raw > half) ? (period - gap_raw) : gap_raw;
               priority if (scaled_ff <= thr_ff) begin
                  color_in = '0;
               end else if (scaled_ff < thr_ff + bbbl_pkg::SEG_MIDDLE) begin
                  color_in = cfg.hsl_low;
               end else if (scaled_ff < thr_ff + bbbl_pkg::SEG_HIGH) begin
                  color_in = cfg.hsl_middle;
               end else begin
                  color_in = cfg.hsl_high;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_start    = 1'b1;
            div_dividend = 32'(prod);
            div_divisor  = two_h;
            state_in     = ST_LIGHT;
         end
         ST_LIGHT: begin
            if (div_done) begin
               pend_in              = '0;
               pend_in.kind         = bbbl_pkg::KIND_PIXEL;
               pend_in.bar_position = idx_ff;
               pend_in.hue          = color_ff[15:0];
               pend_in.saturation   = color_ff[23:16];
               pend_in.lightness    = div_quo[7:0];
               pend_in.last         = idx_ff == LAST_POS;
               state_in             = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = pend_ff;
               rsp_data_in.frames_left = frames_ff;
               if (pix_run_ff && !pend_ff.last) begin
                  idx_in       = idx_ff + bbbl_pkg::POS_W'(1);
                  num_in       = num_next;
                  thr_in       = thr_ff + bbbl_pkg::SEG_STEP;
                  div_start    = 1'b1;
                  div_dividend = num_next;
                  state_in     = ST_POINT;
               end else begin
                  pix_run_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frames_ff     <= '0;
         last_alert_ff <= '0;
         pix_run_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frames_ff     <= frames_in;
         last_alert_ff <= last_alert_in;
         pix_run_ff    <= pix_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      idx_ff      <= idx_in;
      num_ff      <= num_in;
      thr_ff      <= thr_in;
      scaled_ff   <= scaled_in;
      peak_ff     <= peak_in;
      gap_ff      <= gap_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_frame_dec: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.func == bbbl_pkg::FUNC_FRAME && frames_ff != '0)
      |=> frames_ff == $past(frames_ff) - 32'd1)
      else $error("frame counter did not step down");

   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == bbbl_pkg::KIND_PIXEL && rsp_data.last)
      |-> rsp_data.bar_position == LAST_POS)
      else $error("last pixel item at wrong position");

   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != bbbl_pkg::KIND_PIXEL)
      |-> (rsp_data.last && rsp_data.lightness == '0))
      else $error("alert or status item malformed");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_PEAK || state_ff == ST_POINT || state_ff == ST_LIGHT))
      else $error("divider result with no consumer");

endmodule
`default_nettype wire
